// ===== rtl/core/iirf_pkg.sv =====
// iirf_pkg: shared types and constants for the direct form I IIR filter core.
// No dependencies; imported by the cell, rounding stage and top level.
package iirf_pkg;

    localparam int COEFF_BITS   = 18;
    localparam int FRAC_BITS    = 14;
    localparam int HIST_DEPTH   = 3;
    localparam int NUM_REGS     = 7;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [COEFF_BITS-1:0] coeff_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FWD0 = 3'd0,
        REG_FWD1 = 3'd1,
        REG_FWD2 = 3'd2,
        REG_FWD3 = 3'd3,
        REG_FB1  = 3'd4,
        REG_FB2  = 3'd5,
        REG_FB3  = 3'd6
    } reg_idx_t;

    localparam coeff_t REG_RESET [NUM_REGS] = '{
        18'sd16384, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
    };

    // control shared by every cell in the row
    typedef struct packed {
        logic shift;
        logic restart;
    } cell_ctl_t;

endpackage

// ===== rtl/core/iirf_if.sv =====
// iirf_if: valid/ready channel interfaces for filter input and output items.
// Depends on nothing; used by iir_difference_equation_filter_core.
interface iirf_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface iirf_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

// ===== rtl/core/iir_difference_equation_filter_core.sv =====
// iir_difference_equation_filter_core: direct form I IIR filter, row of tap cells.
// Depends on iirf_pkg, iirf_if, iirf_cell, iirf_rndsat.
//
//  channel   dir  fields                        handshake
//  in_ch     in   sample_in, restart            valid/ready
//  out_ch    out  sample_out, saturated         valid/ready
//  cfg       in   cfg_index, cfg_data           cfg_we, no wait
//
// One item per clock unless out_ch stalls; out register loads on accept.
// The y[n-1] feedback (multiply, sum chain, round/saturate) is combinational.
// Reset clears histories, coefficients to defaults, output valid low.
// in_ch.ready drops only while a result waits and out_ch is stalled.
module iir_difference_equation_filter_core
    import iirf_pkg::*;
#(
    parameter int NUM_FWD_TAPS = 4,
    parameter int NUM_FB_TAPS  = 3,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    iirf_in_if.sink                 in_ch,
    iirf_out_if.source              out_ch,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  coeff_t                  cfg_data
);

    localparam int ACC_W = COEFF_BITS + SAMPLE_BITS + 3;
    localparam int NCELL = (NUM_FWD_TAPS > NUM_FB_TAPS + 1) ? NUM_FWD_TAPS : NUM_FB_TAPS + 1;

    coeff_t coef_reg [NUM_REGS];

    logic signed [SAMPLE_BITS-1:0] x_link   [NCELL+1];
    logic signed [SAMPLE_BITS-1:0] y_link   [NCELL+1];
    logic signed [ACC_W-1:0]       acc_link [NCELL+1];

    logic signed [SAMPLE_BITS-1:0] y_new;
    logic                          sat_new;
    logic                          in_accept;
    cell_ctl_t                     ctl;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                coef_reg[i] <= REG_RESET[i];
        end
        else if (cfg_we && (cfg_index <= REG_FB3))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign ctl.shift   = in_accept;
    assign ctl.restart = in_ch.restart;

    assign x_link[0]   = in_ch.sample_in;
    assign y_link[0]   = y_new;
    assign acc_link[0] = '0;

    generate
        for (genvar k = 0; k < NCELL; k++) begin : g_cell
            localparam bit USE_FWD = (k < NUM_FWD_TAPS);
            localparam bit USE_FB  = (k >= 1) && (k <= NUM_FB_TAPS);
            localparam int FWD_IDX = (k <= 3) ? k : 0;
            localparam int FB_IDX  = (k >= 1) ? 3 + k : 4;

            iirf_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .ACC_W       (ACC_W),
                .HAS_TAP     (k > 0),
                .USE_FWD     (USE_FWD),
                .USE_FB      (USE_FB)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .fwd_coeff (coef_reg[FWD_IDX]),
                .fb_coeff  (coef_reg[FB_IDX]),
                .x_in      (x_link[k]),
                .y_in      (y_link[k]),
                .acc_in    (acc_link[k]),
                .x_out     (x_link[k+1]),
                .y_out     (y_link[k+1]),
                .acc_out   (acc_link[k+1])
            );
        end
    endgenerate

    iirf_rndsat #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_rndsat (
        .acc (acc_link[NCELL]),
        .y   (y_new),
        .sat (sat_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_out_reg <= '0;
            saturated_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            sample_out_reg <= y_new;
            saturated_reg  <= sat_new;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = sample_out_reg;
    assign out_ch.saturated  = saturated_reg;

`ifndef SYNTHESIS
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while result stalled");

    a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_ch.valid)
        else $error("accepted item produced no result");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.saturated |->
            (out_ch.sample_out == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
            (out_ch.sample_out == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("saturated result not at a rail");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(out_ch.sample_out))
        else $error("result changed without an accepted item");
`endif

endmodule

// ===== rtl/core/iirf_cell.sv =====
// iirf_cell: tap cell; holds x[n-k], y[n-k] if HAS_TAP; adds fwd, subtracts fb product.
// Depends on iirf_pkg.
module iirf_cell
    import iirf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 37,
    parameter bit HAS_TAP     = 1'b1,
    parameter bit USE_FWD     = 1'b1,
    parameter bit USE_FB      = 1'b1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctl_t                     ctl,
    input  coeff_t                        fwd_coeff,
    input  coeff_t                        fb_coeff,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic signed [SAMPLE_BITS-1:0] y_in,
    input  logic signed [ACC_W-1:0]       acc_in,
    output logic signed [SAMPLE_BITS-1:0] x_out,
    output logic signed [SAMPLE_BITS-1:0] y_out,
    output logic signed [ACC_W-1:0]       acc_out
);

    localparam int PW = COEFF_BITS + SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] x_eff;
    logic signed [SAMPLE_BITS-1:0] y_eff;
    logic signed [PW-1:0]          fwd_prod;
    logic signed [PW-1:0]          fb_prod;

    generate
        if (HAS_TAP) begin : g_tap
            logic signed [SAMPLE_BITS-1:0] x_reg;
            logic signed [SAMPLE_BITS-1:0] y_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    x_reg <= '0;
                    y_reg <= '0;
                end
                else if (ctl.shift)
                begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                end
            end

            // restart: past terms count as zero for this item and are flushed
            assign x_eff = ctl.restart ? '0 : x_reg;
            assign y_eff = ctl.restart ? '0 : y_reg;
        end
        else begin : g_head
            assign x_eff = x_in;
            assign y_eff = y_in;
        end

        if (USE_FWD) begin : g_fwd
            assign fwd_prod = fwd_coeff * x_eff;
        end
        else begin : g_no_fwd
            assign fwd_prod = '0;
        end

        if (USE_FB && HAS_TAP) begin : g_fb
            assign fb_prod = fb_coeff * y_eff;
        end
        else begin : g_no_fb
            assign fb_prod = '0;
        end
    endgenerate

    assign x_out   = x_eff;
    assign y_out   = y_eff;
    assign acc_out = acc_in + ACC_W'(fwd_prod) - ACC_W'(fb_prod);

endmodule

// ===== rtl/core/iirf_rndsat.sv =====
// iirf_rndsat: round half up by FRAC_BITS and saturate to SAMPLE_BITS signed bits.
// Depends on iirf_pkg.
module iirf_rndsat
    import iirf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 37
) (
    input  logic signed [ACC_W-1:0]       acc,
    output logic signed [SAMPLE_BITS-1:0] y,
    output logic                          sat
);

    localparam int BW = ACC_W + 1;
    localparam int SW = BW - FRAC_BITS;

    logic signed [BW-1:0] biased;
    logic signed [SW-1:0] shifted;
    logic                 all_zero;
    logic                 all_ones;

    assign biased   = BW'(acc) + BW'(signed'(1 <<< (FRAC_BITS - 1)));
    assign shifted  = biased[BW-1:FRAC_BITS];
    assign all_zero = ~|shifted[SW-1:SAMPLE_BITS-1];
    assign all_ones = &shifted[SW-1:SAMPLE_BITS-1];
    assign sat      = !(all_zero || all_ones);

    always_comb
    begin
        if (!sat)
            y = shifted[SAMPLE_BITS-1:0];
        else if (shifted[SW-1])
            y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

endmodule
